[design/icg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icg_pkg: shared types and constants of the inverse congruential step unit
// Holds the register indexes, the reset values, the sequencer states and the
// control word of the shared modular arithmetic unit.
// ----------------------------------------------------------------------------
package icg_pkg;

   localparam int ICG_VALUE_WIDTH     = 16;
   localparam int ICG_CSR_INDEX_WIDTH = 2;

   localparam int ICG_MULTIPLIER_RESET = 1;
   localparam int ICG_INCREMENT_RESET  = 0;
   localparam int ICG_MODULUS_RESET    = 65521;

   typedef enum logic [ICG_CSR_INDEX_WIDTH-1:0] {
      CSR_MULTIPLIER = 2'd0,
      CSR_INCREMENT  = 2'd1,
      CSR_MODULUS    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE_SEED,
      ST_SEARCH,
      ST_MULTIPLY,
      ST_REDUCE_RESULT
   } state_type;

   typedef enum logic {
      ALU_SHIFT,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       shift_bit;
   } alu_ctrl_type;

endpackage
`default_nettype wire

[design/icg_mod_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icg_mod_alu: shared modular step unit
// Forms either a shift-in of one dividend bit or an addition, then brings the
// sum below the modulus with one compare and subtract.
// ----------------------------------------------------------------------------
module icg_mod_alu #(
   parameter int VALUE_WIDTH = icg_pkg::ICG_VALUE_WIDTH
) (
   input  icg_pkg::alu_ctrl_type   ctrl,
   input  logic [VALUE_WIDTH-1:0]  operand_a,
   input  logic [VALUE_WIDTH-1:0]  operand_b,
   input  logic [VALUE_WIDTH-1:0]  modulus,
   output logic [VALUE_WIDTH-1:0]  result
);
   import icg_pkg::*;

   logic [VALUE_WIDTH:0] sum;
   logic [VALUE_WIDTH:0] diff;

   always_comb begin
      case (ctrl.op)
         ALU_SHIFT: sum = {operand_a, ctrl.shift_bit};
         ALU_ADD:   sum = {1'b0, operand_a} + {1'b0, operand_b};
         default:   sum = '0;
      endcase
      diff = sum - {1'b0, modulus};
      if (sum >= {1'b0, modulus}) begin
         result = diff[VALUE_WIDTH-1:0];
      end else begin
         result = sum[VALUE_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

[design/inverse_congruential_step_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_congruential_step_unit: one inverse congruential generator step
// Reduces the seed modulo the modulus, searches its modular inverse, and
// returns (multiplier * inverse + increment) mod modulus with a flag that
// is set when no inverse exists.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Handshake
//   request   start, busy, req_seed_value             start high, busy low
//   response  rsp_valid, rsp_next_value,              one-cycle strobe
//             rsp_no_inverse
//   control   csr_valid, csr_ready, csr_index,        valid and ready high
//             csr_data
//
// A word with a modulus below two is answered in the cycle after it is taken.
// Otherwise the word runs through ST_REDUCE_SEED, ST_SEARCH, ST_MULTIPLY and
// ST_REDUCE_RESULT in that order; the search stops at the inverse, or at
// modulus - 1 when none exists. Reduction and search steps run through the
// one modular step unit, one step per cycle; the multiply has its own product.
// Reset is synchronous and needs no clearing pass; the strobe is not held.
//
module inverse_congruential_step_unit #(
   parameter int VALUE_WIDTH = icg_pkg::ICG_VALUE_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [VALUE_WIDTH-1:0]                   req_seed_value,
   output logic                                     rsp_valid,
   output logic [VALUE_WIDTH-1:0]                   rsp_next_value,
   output logic                                     rsp_no_inverse,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [icg_pkg::ICG_CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [VALUE_WIDTH-1:0]                   csr_data
);
   import icg_pkg::*;

   localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
   localparam int COUNT_WIDTH = $clog2(WIDE_WIDTH + 1);

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  multiplier_ff;
   logic [VALUE_WIDTH-1:0]  increment_ff;
   logic [VALUE_WIDTH-1:0]  modulus_ff;
   logic [WIDE_WIDTH-1:0]   dividend_ff, dividend_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [VALUE_WIDTH-1:0]  reduced_seed_ff, reduced_seed_in;
   logic [VALUE_WIDTH-1:0]  search_ff, search_in;
   logic [VALUE_WIDTH-1:0]  candidate_ff, candidate_in;
   logic [VALUE_WIDTH-1:0]  running_product_ff, running_product_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_next_value_ff, rsp_next_value_in;
   logic                    rsp_no_inverse_ff, rsp_no_inverse_in;

   alu_ctrl_type            alu_ctrl;
   logic [VALUE_WIDTH-1:0]  alu_result;
   logic [VALUE_WIDTH-1:0]  search_next;
   logic [WIDE_WIDTH-1:0]   product;

   icg_mod_alu #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_alu (
      .ctrl      (alu_ctrl),
      .operand_a (acc_ff),
      .operand_b (reduced_seed_ff),
      .modulus   (modulus_ff),
      .result    (alu_result)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_value = rsp_next_value_ff;
   assign rsp_no_inverse = rsp_no_inverse_ff;

   assign search_next = search_ff + VALUE_WIDTH'(1);
   assign product     = {{VALUE_WIDTH{1'b0}}, multiplier_ff}
                      * {{VALUE_WIDTH{1'b0}}, candidate_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= VALUE_WIDTH'(ICG_MULTIPLIER_RESET);
         increment_ff  <= VALUE_WIDTH'(ICG_INCREMENT_RESET);
         modulus_ff    <= VALUE_WIDTH'(ICG_MODULUS_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MULTIPLIER: multiplier_ff <= csr_data;
            CSR_INCREMENT:  increment_ff  <= csr_data;
            CSR_MODULUS:    modulus_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         reduced_seed_ff    <= '0;
         candidate_ff       <= '0;
         running_product_ff <= '0;
      end else begin
         state_ff           <= state_in;
         rsp_valid_ff       <= rsp_valid_in;
         reduced_seed_ff    <= reduced_seed_in;
         candidate_ff       <= candidate_in;
         running_product_ff <= running_product_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff       <= dividend_in;
      acc_ff            <= acc_in;
      count_ff          <= count_in;
      search_ff         <= search_in;
      rsp_next_value_ff <= rsp_next_value_in;
      rsp_no_inverse_ff <= rsp_no_inverse_in;
   end

   always_comb begin
      state_in           = state_ff;
      dividend_in        = dividend_ff;
      acc_in             = acc_ff;
      count_in           = count_ff;
      reduced_seed_in    = reduced_seed_ff;
      search_in          = search_ff;
      candidate_in       = candidate_ff;
      running_product_in = running_product_ff;
      rsp_valid_in       = 1'b0;
      rsp_next_value_in  = rsp_next_value_ff;
      rsp_no_inverse_in  = rsp_no_inverse_ff;

      alu_ctrl.op        = (state_ff == ST_SEARCH) ? ALU_ADD : ALU_SHIFT;
      alu_ctrl.shift_bit = dividend_ff[WIDE_WIDTH-1];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (modulus_ff < VALUE_WIDTH'(2)) begin
                  reduced_seed_in    = '0;
                  candidate_in       = '0;
                  running_product_in = '0;
                  rsp_valid_in       = 1'b1;
                  rsp_next_value_in  = '0;
                  rsp_no_inverse_in  = 1'b1;
               end else begin
                  dividend_in = {req_seed_value, {VALUE_WIDTH{1'b0}}};
                  acc_in      = '0;
                  count_in    = COUNT_WIDTH'(VALUE_WIDTH);
                  state_in    = ST_REDUCE_SEED;
               end
            end
         end
         ST_REDUCE_SEED: begin
            acc_in      = alu_result;
            dividend_in = dividend_ff << 1;
            count_in    = count_ff - COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(1)) begin
               reduced_seed_in = alu_result;
               acc_in          = '0;
               search_in       = '0;
               state_in        = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            acc_in    = alu_result;
            search_in = search_next;
            if (alu_result == VALUE_WIDTH'(1)) begin
               candidate_in       = search_next;
               running_product_in = alu_result;
               rsp_no_inverse_in  = 1'b0;
               state_in           = ST_MULTIPLY;
            end else if (search_next == modulus_ff - VALUE_WIDTH'(1)) begin
               candidate_in       = '0;
               running_product_in = '0;
               rsp_no_inverse_in  = 1'b1;
               state_in           = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            dividend_in = product + {{VALUE_WIDTH{1'b0}}, increment_ff};
            acc_in      = '0;
            count_in    = COUNT_WIDTH'(WIDE_WIDTH);
            state_in    = ST_REDUCE_RESULT;
         end
         ST_REDUCE_RESULT: begin
            acc_in      = alu_result;
            dividend_in = dividend_ff << 1;
            count_in    = count_ff - COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(1)) begin
               rsp_valid_in      = 1'b1;
               rsp_next_value_in = alu_result;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result word is only issued while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while the sequencer is busy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (acc_ff < modulus_ff))
      else $error("running product not reduced below the modulus");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (search_ff < modulus_ff - VALUE_WIDTH'(1)))
      else $error("inverse search ran past its bound");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_next_value_ff < modulus_ff)
                        || (rsp_next_value_ff == '0)))
      else $error("result word not reduced below the modulus");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_no_inverse_ff) |-> (running_product_ff == VALUE_WIDTH'(1)))
      else $error("inverse reported without a unit product");

endmodule
`default_nettype wire
